// File: rtl/core/qapm_pkg.sv
package qapm_pkg;

    // field widths
    localparam int OP_W       = 2;
    localparam int ANGLE_W    = 17;
    localparam int PULSE_W    = 12;
    localparam int OFFSET_W   = PULSE_W + 1;
    localparam int ERR_W      = 18;
    localparam int DERR_W     = ERR_W + 1;
    localparam int INTEG_W    = 32;
    localparam int GAIN_W     = 16;
    localparam int MOTOR_W    = 11;
    localparam int TERM_W     = 10;
    localparam int MIX_W      = 14;
    localparam int CFG_IDX_W  = 3;
    localparam int SP_MAG_W   = 16;
    localparam int STEP_MAG_W = 9;
    localparam int STEP_W     = STEP_MAG_W + 1;

    // product and sum widths of the PID terms
    localparam int PROP_W = GAIN_W + 1 + ERR_W;
    localparam int INTP_W = GAIN_W + 1 + INTEG_W;
    localparam int DERP_W = GAIN_W + 1 + DERR_W;
    localparam int SUM_W  = INTP_W + 1;
    localparam int TERM_FRAC = 18;

    // operation codes
    localparam logic [OP_W-1:0] OP_FLY     = 2'd0;
    localparam logic [OP_W-1:0] OP_GROUND  = 2'd1;
    localparam logic [OP_W-1:0] OP_STANDBY = 2'd2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_KP_TILT    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_KI_TILT    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_KD_TILT    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_KP_HEADING = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_KD_HEADING = 3'd4;

    localparam logic [GAIN_W-1:0] KP_TILT_RST    = 16'd1331;
    localparam logic [GAIN_W-1:0] KI_TILT_RST    = 16'd51;
    localparam logic [GAIN_W-1:0] KD_TILT_RST    = 16'd15360;
    localparam logic [GAIN_W-1:0] KP_HEADING_RST = 16'd205;
    localparam logic [GAIN_W-1:0] KD_HEADING_RST = 16'd5120;

    localparam logic signed [OFFSET_W-1:0] STICK_CENTER = 13'sd1500;
    localparam logic [PULSE_W-1:0]         YAW_DEADBAND = 12'd20;
    localparam int DEG180_Q8  = 180 * 256;
    localparam int DEG360_Q8  = 360 * 256;
    localparam int TERM_LIMIT = 400;
    localparam int MOTOR_MIN  = 1200;
    localparam int MOTOR_MAX  = 1800;
    localparam int MOTOR_IDLE = 1000;

    // x*256/15 = (x*RECIP15) >> 16, exact for x < 4096
    localparam logic [20:0] RECIP15       = 21'd1118482;
    localparam int          RECIP15_SHIFT = 16;
    localparam int          RECIP15_PW    = PULSE_W + 21;
    // x*256/1500 = (x*RECIP1500) >> 21, exact for x < 4096
    localparam logic [18:0] RECIP1500       = 19'd357914;
    localparam int          RECIP1500_SHIFT = 21;
    localparam int          RECIP1500_PW    = PULSE_W + 19;

    localparam logic signed [INTEG_W-1:0] INTEG_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [INTEG_W-1:0] INTEG_MIN = 32'sh8000_0000;

    // pipeline register stages
    localparam int NUM_STAGES = 10;
    localparam int ST_IN   = 0;
    localparam int ST_MAG  = 1;
    localparam int ST_QUO  = 2;
    localparam int ST_ERR  = 3;
    localparam int ST_YAW  = 4;
    localparam int ST_LOOP = 5;
    localparam int ST_PROD = 6;
    localparam int ST_SUM  = 7;
    localparam int ST_TERM = 8;
    localparam int ST_OUT  = 9;

    typedef struct packed {
        logic [NUM_STAGES-1:0] ld;
        logic [NUM_STAGES-1:0] fire;
    } t_pipe_ctl;

    typedef struct packed {
        logic [GAIN_W-1:0] kp_tilt;
        logic [GAIN_W-1:0] ki_tilt;
        logic [GAIN_W-1:0] kd_tilt;
        logic [GAIN_W-1:0] kp_heading;
        logic [GAIN_W-1:0] kd_heading;
    } t_gains;

    typedef struct packed {
        logic [OP_W-1:0]           op;
        logic signed [ANGLE_W-1:0] roll;
        logic signed [ANGLE_W-1:0] pitch;
        logic signed [ANGLE_W-1:0] yaw;
        logic [PULSE_W-1:0]        thr;
        logic [PULSE_W-1:0]        roll_stick;
        logic [PULSE_W-1:0]        pitch_stick;
        logic [PULSE_W-1:0]        yaw_stick;
    } t_item;

    typedef struct packed {
        logic [OP_W-1:0]           op;
        logic signed [ANGLE_W-1:0] roll;
        logic signed [ANGLE_W-1:0] pitch;
        logic signed [ANGLE_W-1:0] yaw;
        logic [PULSE_W-1:0]        thr;
        logic [PULSE_W-1:0]        roll_mag;
        logic [PULSE_W-1:0]        pitch_mag;
        logic [PULSE_W-1:0]        yaw_mag;
        logic                      roll_neg;
        logic                      pitch_neg;
        logic                      yaw_neg;
        logic                      yaw_move;
    } t_mag;

    typedef struct packed {
        logic [OP_W-1:0]           op;
        logic signed [ANGLE_W-1:0] roll;
        logic signed [ANGLE_W-1:0] pitch;
        logic signed [ANGLE_W-1:0] yaw;
        logic [PULSE_W-1:0]        thr;
        logic signed [ANGLE_W-1:0] sp_roll;
        logic signed [ANGLE_W-1:0] sp_pitch;
        logic signed [STEP_W-1:0]  hd_step;
        logic                      yaw_move;
    } t_quo;

    typedef struct packed {
        logic                      fly;
        logic [PULSE_W-1:0]        thr;
        logic signed [ANGLE_W-1:0] yaw;
        logic signed [ANGLE_W-1:0] heading;
        logic signed [ERR_W-1:0]   roll_err;
        logic signed [ERR_W-1:0]   pitch_err;
    } t_err;

    typedef struct packed {
        logic                    fly;
        logic [PULSE_W-1:0]      thr;
        logic signed [ERR_W-1:0] roll_err;
        logic signed [ERR_W-1:0] pitch_err;
        logic signed [ERR_W-1:0] yaw_err;
    } t_yerr;

    typedef struct packed {
        logic                      fly;
        logic [PULSE_W-1:0]        thr;
        logic signed [ERR_W-1:0]   roll_err;
        logic signed [INTEG_W-1:0] roll_int;
        logic signed [DERR_W-1:0]  roll_der;
        logic signed [ERR_W-1:0]   pitch_err;
        logic signed [INTEG_W-1:0] pitch_int;
        logic signed [DERR_W-1:0]  pitch_der;
        logic signed [ERR_W-1:0]   yaw_err;
        logic signed [DERR_W-1:0]  yaw_der;
    } t_loop;

    typedef struct packed {
        logic                     fly;
        logic [PULSE_W-1:0]       thr;
        logic signed [PROP_W-1:0] roll_p;
        logic signed [INTP_W-1:0] roll_i;
        logic signed [DERP_W-1:0] roll_d;
        logic signed [PROP_W-1:0] pitch_p;
        logic signed [INTP_W-1:0] pitch_i;
        logic signed [DERP_W-1:0] pitch_d;
        logic signed [PROP_W-1:0] yaw_p;
        logic signed [DERP_W-1:0] yaw_d;
    } t_prod;

    typedef struct packed {
        logic                    fly;
        logic [PULSE_W-1:0]      thr;
        logic signed [SUM_W-1:0] roll_sum;
        logic signed [SUM_W-1:0] pitch_sum;
        logic signed [SUM_W-1:0] yaw_sum;
    } t_sum;

    typedef struct packed {
        logic                     fly;
        logic [PULSE_W-1:0]       thr;
        logic signed [TERM_W-1:0] roll;
        logic signed [TERM_W-1:0] pitch;
        logic signed [TERM_W-1:0] yaw;
    } t_term;

    typedef struct packed {
        logic [MOTOR_W-1:0] left_front;
        logic [MOTOR_W-1:0] right_front;
        logic [MOTOR_W-1:0] left_back;
        logic [MOTOR_W-1:0] right_back;
    } t_motors;

endpackage

// File: rtl/core/qapm_in_if.sv
interface qapm_in_if import qapm_pkg::*; ();
    logic                      valid;
    logic                      ready;
    logic [OP_W-1:0]           op;
    logic signed [ANGLE_W-1:0] roll_angle;
    logic signed [ANGLE_W-1:0] pitch_angle;
    logic signed [ANGLE_W-1:0] yaw_angle;
    logic [PULSE_W-1:0]        throttle_pulse;
    logic [PULSE_W-1:0]        roll_stick;
    logic [PULSE_W-1:0]        pitch_stick;
    logic [PULSE_W-1:0]        yaw_stick;

    modport source (
        output valid, op, roll_angle, pitch_angle, yaw_angle,
               throttle_pulse, roll_stick, pitch_stick, yaw_stick,
        input  ready
    );
    modport sink (
        input  valid, op, roll_angle, pitch_angle, yaw_angle,
               throttle_pulse, roll_stick, pitch_stick, yaw_stick,
        output ready
    );
endinterface

// File: rtl/core/qapm_out_if.sv
interface qapm_out_if import qapm_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [MOTOR_W-1:0] motor_left_front;
    logic [MOTOR_W-1:0] motor_right_front;
    logic [MOTOR_W-1:0] motor_left_back;
    logic [MOTOR_W-1:0] motor_right_back;

    modport source (
        output valid, motor_left_front, motor_right_front,
               motor_left_back, motor_right_back,
        input  ready
    );
    modport sink (
        input  valid, motor_left_front, motor_right_front,
               motor_left_back, motor_right_back,
        output ready
    );
endinterface

// File: rtl/core/qapm_cfg_if.sv
interface qapm_cfg_if import qapm_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [GAIN_W-1:0]    data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

// File: rtl/core/qapm_flow.sv
module qapm_flow import qapm_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    input  logic      i_out_ready,
    output logic      o_in_ready,
    output logic      o_out_valid,
    output t_pipe_ctl o_ctl
);

    logic [NUM_STAGES-1:0] r_valid;
    logic [NUM_STAGES-1:0] n_valid;
    logic [NUM_STAGES-1:0] ld;
    logic [NUM_STAGES-1:0] upstream;

    assign upstream = {r_valid[NUM_STAGES-2:0], i_in_valid};

    // a stage loads when it is empty or its item moves on; bubbles collapse
    always_comb begin
        ld[NUM_STAGES-1] = !r_valid[NUM_STAGES-1] || i_out_ready;
        for (int k = NUM_STAGES - 2; k >= 0; k--) begin
            ld[k] = !r_valid[k] || ld[k+1];
        end
    end

    always_comb begin
        for (int k = 0; k < NUM_STAGES; k++) begin
            n_valid[k] = ld[k] ? upstream[k] : r_valid[k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else begin
            r_valid <= n_valid;
        end
    end

    assign o_ctl.ld    = ld;
    assign o_ctl.fire  = ld & upstream;
    assign o_in_ready  = ld[ST_IN];
    assign o_out_valid = r_valid[ST_OUT];

    a_full_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (&r_valid && !i_out_ready) |-> !o_in_ready)
        else $error("input taken while pipeline full and output stalled");

    a_item_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        1'b1 |=> $countones(r_valid) == $past($countones(r_valid))
                 + $past(int'(i_in_valid && o_in_ready))
                 - $past(int'(r_valid[ST_OUT] && i_out_ready)))
        else $error("beat lost or duplicated in pipeline");

endmodule

// File: rtl/core/qapm_setpoint.sv
module qapm_setpoint import qapm_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_pipe_ctl i_ctl,
    input  t_item     i_item,
    output t_err      o_err
);

    t_item r_in;
    t_mag  r_mag, n_mag;
    t_quo  r_quo, n_quo;
    t_err  r_err, n_err;

    logic signed [ANGLE_W-1:0] r_heading, n_heading;

    logic signed [OFFSET_W-1:0]  roll_off, pitch_off, yaw_off;
    logic [RECIP15_PW-1:0]       roll_prod, pitch_prod;
    logic [RECIP1500_PW-1:0]     yaw_prod;
    logic signed [ANGLE_W-1:0]   roll_q, pitch_q;
    logic signed [STEP_W-1:0]    yaw_q;
    logic signed [ANGLE_W:0]     hd_sum;
    logic signed [ANGLE_W-1:0]   hd_wrap;

    always_ff @(posedge i_clk) begin
        if (i_ctl.ld[ST_IN]) begin
            r_in <= i_item;
        end
    end

    // center the sticks and split into sign and magnitude
    always_comb begin
        roll_off  = $signed({1'b0, r_in.roll_stick}) - STICK_CENTER;
        pitch_off = $signed({1'b0, r_in.pitch_stick}) - STICK_CENTER;
        yaw_off   = $signed({1'b0, r_in.yaw_stick}) - STICK_CENTER;

        n_mag.op        = r_in.op;
        n_mag.roll      = r_in.roll;
        n_mag.pitch     = r_in.pitch;
        n_mag.yaw       = r_in.yaw;
        n_mag.thr       = r_in.thr;
        n_mag.roll_neg  = roll_off[OFFSET_W-1];
        n_mag.pitch_neg = pitch_off[OFFSET_W-1];
        n_mag.yaw_neg   = yaw_off[OFFSET_W-1];
        n_mag.roll_mag  = roll_off[OFFSET_W-1] ? PULSE_W'(-roll_off)
                                               : roll_off[PULSE_W-1:0];
        n_mag.pitch_mag = pitch_off[OFFSET_W-1] ? PULSE_W'(-pitch_off)
                                                : pitch_off[PULSE_W-1:0];
        n_mag.yaw_mag   = yaw_off[OFFSET_W-1] ? PULSE_W'(-yaw_off)
                                              : yaw_off[PULSE_W-1:0];
        n_mag.yaw_move  = n_mag.yaw_mag >= YAW_DEADBAND;
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.ld[ST_MAG]) begin
            r_mag <= n_mag;
        end
    end

    // constant division by reciprocal multiply, then restore the sign (pitch takes the opposite sign)
    always_comb begin
        roll_prod  = RECIP15_PW'(r_mag.roll_mag) * RECIP15_PW'(RECIP15);
        pitch_prod = RECIP15_PW'(r_mag.pitch_mag) * RECIP15_PW'(RECIP15);
        yaw_prod   = RECIP1500_PW'(r_mag.yaw_mag) * RECIP1500_PW'(RECIP1500);

        roll_q  = $signed({1'b0, roll_prod[RECIP15_SHIFT +: SP_MAG_W]});
        pitch_q = $signed({1'b0, pitch_prod[RECIP15_SHIFT +: SP_MAG_W]});
        yaw_q   = $signed({1'b0, yaw_prod[RECIP1500_SHIFT +: STEP_MAG_W]});

        n_quo.op       = r_mag.op;
        n_quo.roll     = r_mag.roll;
        n_quo.pitch    = r_mag.pitch;
        n_quo.yaw      = r_mag.yaw;
        n_quo.thr      = r_mag.thr;
        n_quo.sp_roll  = r_mag.roll_neg ? -roll_q : roll_q;
        n_quo.sp_pitch = r_mag.pitch_neg ? pitch_q : -pitch_q;
        n_quo.hd_step  = r_mag.yaw_neg ? -yaw_q : yaw_q;
        n_quo.yaw_move = r_mag.yaw_move;
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.ld[ST_QUO]) begin
            r_quo <= n_quo;
        end
    end

    // heading target: in fly, step and wrap once at +-180 degrees; ground latches yaw
    always_comb begin
        hd_sum = {r_heading[ANGLE_W-1], r_heading}
               + (ANGLE_W+1)'(r_quo.hd_step);
        if (hd_sum > DEG180_Q8) begin
            hd_wrap = ANGLE_W'(hd_sum - DEG360_Q8);
        end else if (hd_sum < -DEG180_Q8) begin
            hd_wrap = ANGLE_W'(hd_sum + DEG360_Q8);
        end else begin
            hd_wrap = hd_sum[ANGLE_W-1:0];
        end

        n_heading = r_heading;
        if (r_quo.op == OP_FLY) begin
            if (r_quo.yaw_move) begin
                n_heading = hd_wrap;
            end
        end else if (r_quo.op == OP_GROUND) begin
            n_heading = r_quo.yaw;
        end

        n_err.fly       = r_quo.op == OP_FLY;
        n_err.thr       = r_quo.thr;
        n_err.yaw       = r_quo.yaw;
        n_err.heading   = n_heading;
        n_err.roll_err  = ERR_W'(r_quo.roll) - ERR_W'(r_quo.sp_roll);
        n_err.pitch_err = ERR_W'(r_quo.pitch) - ERR_W'(r_quo.sp_pitch);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_heading <= '0;
        end else if (i_ctl.fire[ST_ERR]) begin
            r_heading <= n_heading;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.ld[ST_ERR]) begin
            r_err <= n_err;
        end
    end

    assign o_err = r_err;

endmodule

// File: rtl/core/qapm_loop.sv
module qapm_loop import qapm_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_pipe_ctl i_ctl,
    input  t_err      i_err,
    output t_loop     o_loop
);

    t_yerr r_yerr, n_yerr;
    t_loop r_loop, n_loop;

    logic signed [INTEG_W-1:0] r_roll_int, n_roll_int;
    logic signed [INTEG_W-1:0] r_pitch_int, n_pitch_int;
    logic signed [ERR_W-1:0]   r_roll_prev, n_roll_prev;
    logic signed [ERR_W-1:0]   r_pitch_prev, n_pitch_prev;
    logic signed [ERR_W-1:0]   r_yaw_prev, n_yaw_prev;

    logic signed [ERR_W-1:0]   yaw_diff;
    logic signed [INTEG_W-1:0] roll_sat, pitch_sat;

    function automatic logic signed [INTEG_W-1:0] sat_add(
        input logic signed [INTEG_W-1:0] acc,
        input logic signed [ERR_W-1:0]   err
    );
        logic signed [INTEG_W:0] sum;
        sum = {acc[INTEG_W-1], acc} + (INTEG_W+1)'(err);
        if (sum[INTEG_W] != sum[INTEG_W-1]) begin
            return sum[INTEG_W] ? INTEG_MIN : INTEG_MAX;
        end
        return sum[INTEG_W-1:0];
    endfunction

    // heading error, negated when its magnitude exceeds 180 degrees
    always_comb begin
        yaw_diff = ERR_W'(i_err.yaw) - ERR_W'(i_err.heading);
        n_yerr.fly       = i_err.fly;
        n_yerr.thr       = i_err.thr;
        n_yerr.roll_err  = i_err.roll_err;
        n_yerr.pitch_err = i_err.pitch_err;
        if (yaw_diff > DEG180_Q8 || yaw_diff < -DEG180_Q8) begin
            n_yerr.yaw_err = -yaw_diff;
        end else begin
            n_yerr.yaw_err = yaw_diff;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.ld[ST_YAW]) begin
            r_yerr <= n_yerr;
        end
    end

    always_comb begin
        roll_sat  = sat_add(r_roll_int, r_yerr.roll_err);
        pitch_sat = sat_add(r_pitch_int, r_yerr.pitch_err);

        if (r_yerr.fly) begin
            n_roll_int   = roll_sat;
            n_pitch_int  = pitch_sat;
            n_roll_prev  = r_yerr.roll_err;
            n_pitch_prev = r_yerr.pitch_err;
            n_yaw_prev   = r_yerr.yaw_err;
        end else begin
            // ground and standby clear the tilt loops, keep yaw history
            n_roll_int   = '0;
            n_pitch_int  = '0;
            n_roll_prev  = '0;
            n_pitch_prev = '0;
            n_yaw_prev   = r_yaw_prev;
        end

        n_loop.fly       = r_yerr.fly;
        n_loop.thr       = r_yerr.thr;
        n_loop.roll_err  = r_yerr.roll_err;
        n_loop.roll_int  = roll_sat;
        n_loop.roll_der  = DERR_W'(r_yerr.roll_err) - DERR_W'(r_roll_prev);
        n_loop.pitch_err = r_yerr.pitch_err;
        n_loop.pitch_int = pitch_sat;
        n_loop.pitch_der = DERR_W'(r_yerr.pitch_err) - DERR_W'(r_pitch_prev);
        n_loop.yaw_err   = r_yerr.yaw_err;
        n_loop.yaw_der   = DERR_W'(r_yerr.yaw_err) - DERR_W'(r_yaw_prev);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_roll_int   <= '0;
            r_pitch_int  <= '0;
            r_roll_prev  <= '0;
            r_pitch_prev <= '0;
            r_yaw_prev   <= '0;
        end else if (i_ctl.fire[ST_LOOP]) begin
            r_roll_int   <= n_roll_int;
            r_pitch_int  <= n_pitch_int;
            r_roll_prev  <= n_roll_prev;
            r_pitch_prev <= n_pitch_prev;
            r_yaw_prev   <= n_yaw_prev;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.ld[ST_LOOP]) begin
            r_loop <= n_loop;
        end
    end

    assign o_loop = r_loop;

    a_tilt_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_ctl.fire[ST_LOOP] && !r_yerr.fly) |=>
            (r_roll_int == '0 && r_pitch_int == '0
             && r_roll_prev == '0 && r_pitch_prev == '0))
        else $error("tilt loops not cleared by ground or standby beat");

    a_yaw_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_ctl.fire[ST_LOOP] && !r_yerr.fly) |=> $stable(r_yaw_prev))
        else $error("yaw history changed outside fly mode");

endmodule

// File: rtl/core/qapm_pid.sv
module qapm_pid import qapm_pkg::*; (
    input  logic      i_clk,
    input  t_pipe_ctl i_ctl,
    input  t_gains    i_gains,
    input  t_loop     i_loop,
    output t_term     o_term
);

    t_prod r_prod, n_prod;
    t_sum  r_sum, n_sum;
    t_term r_term, n_term;

    // divide by 2^18 toward zero, then clamp to the term limit
    function automatic logic signed [TERM_W-1:0] term_out(
        input logic signed [SUM_W-1:0] s
    );
        logic signed [SUM_W-1:0] adj;
        logic signed [SUM_W-TERM_FRAC-1:0] t;
        adj = s + $signed({{(SUM_W-TERM_FRAC){1'b0}}, {TERM_FRAC{s[SUM_W-1]}}});
        t   = $signed(adj[SUM_W-1:TERM_FRAC]);
        if (t > TERM_LIMIT) begin
            return TERM_W'(TERM_LIMIT);
        end else if (t < -TERM_LIMIT) begin
            return TERM_W'(-TERM_LIMIT);
        end
        return t[TERM_W-1:0];
    endfunction

    always_comb begin
        n_prod.fly     = i_loop.fly;
        n_prod.thr     = i_loop.thr;
        n_prod.roll_p  = $signed({1'b0, i_gains.kp_tilt}) * i_loop.roll_err;
        n_prod.roll_i  = $signed({1'b0, i_gains.ki_tilt}) * i_loop.roll_int;
        n_prod.roll_d  = $signed({1'b0, i_gains.kd_tilt}) * i_loop.roll_der;
        n_prod.pitch_p = $signed({1'b0, i_gains.kp_tilt}) * i_loop.pitch_err;
        n_prod.pitch_i = $signed({1'b0, i_gains.ki_tilt}) * i_loop.pitch_int;
        n_prod.pitch_d = $signed({1'b0, i_gains.kd_tilt}) * i_loop.pitch_der;
        n_prod.yaw_p   = $signed({1'b0, i_gains.kp_heading}) * i_loop.yaw_err;
        n_prod.yaw_d   = $signed({1'b0, i_gains.kd_heading}) * i_loop.yaw_der;
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.ld[ST_PROD]) begin
            r_prod <= n_prod;
        end
    end

    always_comb begin
        n_sum.fly       = r_prod.fly;
        n_sum.thr       = r_prod.thr;
        n_sum.roll_sum  = SUM_W'(r_prod.roll_p) + SUM_W'(r_prod.roll_i)
                        + SUM_W'(r_prod.roll_d);
        n_sum.pitch_sum = SUM_W'(r_prod.pitch_p) + SUM_W'(r_prod.pitch_i)
                        + SUM_W'(r_prod.pitch_d);
        n_sum.yaw_sum   = SUM_W'(r_prod.yaw_p) + SUM_W'(r_prod.yaw_d);
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.ld[ST_SUM]) begin
            r_sum <= n_sum;
        end
    end

    always_comb begin
        n_term.fly   = r_sum.fly;
        n_term.thr   = r_sum.thr;
        n_term.roll  = term_out(r_sum.roll_sum);
        n_term.pitch = term_out(r_sum.pitch_sum);
        n_term.yaw   = term_out(r_sum.yaw_sum);
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.ld[ST_TERM]) begin
            r_term <= n_term;
        end
    end

    assign o_term = r_term;

endmodule

// File: rtl/core/qapm_mixer.sv
module qapm_mixer import qapm_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_pipe_ctl i_ctl,
    input  logic      i_valid,
    input  t_term     i_term,
    output t_motors   o_motors
);

    t_motors r_out, n_out;

    logic signed [MIX_W-1:0] thr, pp, pr, py;

    function automatic logic [MOTOR_W-1:0] motor_clamp(
        input logic signed [MIX_W-1:0] v
    );
        if (v < MOTOR_MIN) begin
            return MOTOR_W'(MOTOR_MIN);
        end else if (v > MOTOR_MAX) begin
            return MOTOR_W'(MOTOR_MAX);
        end
        return v[MOTOR_W-1:0];
    endfunction

    // X frame: pitch pushes the front pair, roll the right side, yaw one diagonal
    always_comb begin
        thr = $signed({{(MIX_W-PULSE_W){1'b0}}, i_term.thr});
        pp  = MIX_W'(i_term.pitch);
        pr  = MIX_W'(i_term.roll);
        py  = MIX_W'(i_term.yaw);
        if (i_term.fly) begin
            n_out.left_front  = motor_clamp(thr + pp - pr + py);
            n_out.right_front = motor_clamp(thr + pp + pr - py);
            n_out.left_back   = motor_clamp(thr - pp - pr - py);
            n_out.right_back  = motor_clamp(thr - pp + pr + py);
        end else begin
            n_out.left_front  = MOTOR_W'(MOTOR_IDLE);
            n_out.right_front = MOTOR_W'(MOTOR_IDLE);
            n_out.left_back   = MOTOR_W'(MOTOR_IDLE);
            n_out.right_back  = MOTOR_W'(MOTOR_IDLE);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.ld[ST_OUT]) begin
            r_out <= n_out;
        end
    end

    assign o_motors = r_out;

    a_motor_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid |-> (r_out.left_front >= MOTOR_IDLE && r_out.left_front <= MOTOR_MAX
                  && r_out.right_front >= MOTOR_IDLE && r_out.right_front <= MOTOR_MAX
                  && r_out.left_back >= MOTOR_IDLE && r_out.left_back <= MOTOR_MAX
                  && r_out.right_back >= MOTOR_IDLE && r_out.right_back <= MOTOR_MAX))
        else $error("motor command out of range");

    a_idle_all: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && r_out.left_front == MOTOR_IDLE) |->
            (r_out.right_front == MOTOR_IDLE && r_out.left_back == MOTOR_IDLE
             && r_out.right_back == MOTOR_IDLE))
        else $error("idle command not applied to every motor");

endmodule

// File: rtl/core/quadrotor_attitude_pid_mixer.sv
// Quadcopter X-frame attitude PID and motor mixer. One input beat is one
// control period: measured roll/pitch/yaw (Q8.8 degrees) plus four receiver
// pulse widths, and op selects fly, ground (clear tilt loops, latch the
// measured yaw as heading target) or standby (clear tilt loops). Every beat
// gives exactly one output beat of four ESC pulse widths: 1200..1800 in fly,
// 1000 otherwise. The block takes one beat per clock while the output is not
// stalled, and each result passes through the ten-register pipeline: input
// register, stick scaling, reciprocal divide, errors and heading, yaw wrap,
// integrators, gain multiplies, term sums, truncate and clamp, mixer/output
// register. The heading target and the integrators and derivative history
// are registered feedback loops, so back-to-back beats see each other's
// state. Input ready drops only when every stage holds a beat and the output
// is stalled. Gains are written through the config channel (index 0..4:
// kp_tilt, ki_tilt, kd_tilt, kp_heading, kd_heading, unsigned Q6.10); the
// user must write them only while no beat is in flight, which the block
// itself does not enforce; other indexes are ignored.
module quadrotor_attitude_pid_mixer import qapm_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    qapm_in_if.sink     i_in,
    qapm_out_if.source  o_out,
    qapm_cfg_if.sink    i_cfg
);

    t_gains    r_gains;
    t_pipe_ctl ctl;
    t_item     item;
    t_err      err_bus;
    t_loop     loop_bus;
    t_term     term_bus;
    t_motors   motors;
    logic      in_ready;
    logic      out_valid;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gains.kp_tilt    <= KP_TILT_RST;
            r_gains.ki_tilt    <= KI_TILT_RST;
            r_gains.kd_tilt    <= KD_TILT_RST;
            r_gains.kp_heading <= KP_HEADING_RST;
            r_gains.kd_heading <= KD_HEADING_RST;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                CFG_KP_TILT:    r_gains.kp_tilt    <= i_cfg.data;
                CFG_KI_TILT:    r_gains.ki_tilt    <= i_cfg.data;
                CFG_KD_TILT:    r_gains.kd_tilt    <= i_cfg.data;
                CFG_KP_HEADING: r_gains.kp_heading <= i_cfg.data;
                CFG_KD_HEADING: r_gains.kd_heading <= i_cfg.data;
                default: ;
            endcase
        end
    end

    always_comb begin
        item.op          = i_in.op;
        item.roll        = i_in.roll_angle;
        item.pitch       = i_in.pitch_angle;
        item.yaw         = i_in.yaw_angle;
        item.thr         = i_in.throttle_pulse;
        item.roll_stick  = i_in.roll_stick;
        item.pitch_stick = i_in.pitch_stick;
        item.yaw_stick   = i_in.yaw_stick;
    end

    qapm_flow u_flow (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .i_out_ready (o_out.ready),
        .o_in_ready  (in_ready),
        .o_out_valid (out_valid),
        .o_ctl       (ctl)
    );

    qapm_setpoint u_setpoint (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (ctl),
        .i_item  (item),
        .o_err   (err_bus)
    );

    qapm_loop u_loop (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (ctl),
        .i_err   (err_bus),
        .o_loop  (loop_bus)
    );

    qapm_pid u_pid (
        .i_clk   (i_clk),
        .i_ctl   (ctl),
        .i_gains (r_gains),
        .i_loop  (loop_bus),
        .o_term  (term_bus)
    );

    qapm_mixer u_mixer (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (ctl),
        .i_valid  (out_valid),
        .i_term   (term_bus),
        .o_motors (motors)
    );

    assign i_in.ready              = in_ready;
    assign o_out.valid             = out_valid;
    assign o_out.motor_left_front  = motors.left_front;
    assign o_out.motor_right_front = motors.right_front;
    assign o_out.motor_left_back   = motors.left_back;
    assign o_out.motor_right_back  = motors.right_back;

endmodule
